// File: rtl/bbdop_pkg.sv
// Package for the bounding-box drop-one-point block: widths, the extreme-pair type
// and the update, pick and span helpers used by the top level.
// Depends on nothing.
package bbdop_pkg;

	localparam int COORD_BITS = 16;
	localparam int INDEX_BITS = 16;
	localparam int COUNT_BITS = INDEX_BITS + 1;
	localparam int AREA_BITS  = 2 * COORD_BITS;
	localparam int OUT_BITS   = 32;
	localparam int NUM_CAND   = 5;

	localparam logic [COORD_BITS-1:0] COORD_ONES = {COORD_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] CAPACITY   = COUNT_BITS'(1) << INDEX_BITS;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [INDEX_BITS-1:0] index_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [AREA_BITS-1:0]  area_t;

	// Two best values on one side of one axis, each with its point index.
	typedef struct packed {
		coord_t v0;
		coord_t v1;
		index_t i0;
		index_t i1;
	} ext_t;

	// Insert a value into a pair that keeps the two lowest values.
	function automatic ext_t put_low(ext_t e, coord_t v, index_t i, logic first,
			logic second);
		ext_t r;
		r = e;
		if (first) begin
			r.v0 = v;
			r.i0 = i;
		end else if (v < e.v0) begin
			r.v1 = e.v0;
			r.i1 = e.i0;
			r.v0 = v;
			r.i0 = i;
		end else if (second || v < e.v1) begin
			r.v1 = v;
			r.i1 = i;
		end
		return r;
	endfunction

	// Insert a value into a pair that keeps the two highest values.
	function automatic ext_t put_high(ext_t e, coord_t v, index_t i, logic first,
			logic second);
		ext_t r;
		r = e;
		if (first) begin
			r.v0 = v;
			r.i0 = i;
		end else if (v > e.v0) begin
			r.v1 = e.v0;
			r.i1 = e.i0;
			r.v0 = v;
			r.i0 = i;
		end else if (second || v > e.v1) begin
			r.v1 = v;
			r.i1 = i;
		end
		return r;
	endfunction

	// Extreme left once the point with the given index is removed.
	function automatic coord_t pick(ext_t e, index_t drop, logic use_drop);
		return (use_drop && e.i0 == drop) ? e.v1 : e.v0;
	endfunction

	// Side length of the box, zero when the bounds cross.
	function automatic coord_t span(coord_t hi, coord_t lo);
		return (hi >= lo) ? coord_t'(hi - lo) : '0;
	endfunction

endpackage

// File: rtl/bounding_box_drop_one_point.sv
// The area beat passes through the snapshot, product and output registers after the last point of a set is accepted.
// Throughput: one point per cycle while point_ready is high; the running extremes update in the cycle of acceptance.
// The snapshot, product and minimum stages each hold one set and stall only on backpressure.
// Reset (arst_n low, asynchronous) empties all stages and starts a fresh set with no points.
// After the result of a set is captured the running state returns to its reset values.
module bounding_box_drop_one_point (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       point_valid,
	output logic                       point_ready,
	input  bbdop_pkg::coord_t          point_x,
	input  bbdop_pkg::coord_t          point_y,
	input  logic                       last_point,
	output logic                       area_valid,
	input  logic                       area_ready,
	output logic [bbdop_pkg::OUT_BITS-1:0] best_area
);
	import bbdop_pkg::*;

	ext_t   lx_q, hx_q, ly_q, hy_q;
	ext_t   lx_d, hx_d, ly_d, hy_d;
	count_t count_q, count_d;
	coord_t x_c, y_c;
	index_t idx_c;
	logic   room_c, first_c, second_c;
	logic   in_fire;

	ext_t   lx_s1, hx_s1, ly_s1, hy_s1;
	logic   multi_s1, v_s1;
	area_t  area_s2 [NUM_CAND];
	logic   multi_s2, v_s2;
	logic [OUT_BITS-1:0] area_q;
	logic   area_valid_q;

	logic   s1_ready, s2_ready, out_ready;
	index_t drop_c [NUM_CAND];
	area_t  prod_c [NUM_CAND];
	area_t  min_c;

	// Stage readiness: each stage loads when empty or when it is moving on.
	assign out_ready   = !area_valid_q || area_ready;
	assign s2_ready    = !v_s2 || out_ready;
	assign s1_ready    = !v_s1 || s2_ready;
	assign point_ready = s1_ready;
	assign in_fire     = point_valid && point_ready;

	// Next running state for the incoming point.
	always_comb begin
		x_c      = COORD_BITS'(point_x);
		y_c      = COORD_BITS'(point_y);
		idx_c    = count_q[INDEX_BITS-1:0];
		room_c   = (count_q < CAPACITY);
		first_c  = (count_q == '0);
		second_c = (count_q == count_t'(1));
		lx_d     = lx_q;
		hx_d     = hx_q;
		ly_d     = ly_q;
		hy_d     = hy_q;
		count_d  = count_q;
		if (room_c) begin
			lx_d    = put_low(lx_q, x_c, idx_c, first_c, second_c);
			hx_d    = put_high(hx_q, x_c, idx_c, first_c, second_c);
			ly_d    = put_low(ly_q, y_c, idx_c, first_c, second_c);
			hy_d    = put_high(hy_q, y_c, idx_c, first_c, second_c);
			count_d = count_t'(count_q + count_t'(1));
		end
	end

	// Running extremes and point count; cleared after the last point of a set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			lx_q    <= '{v0: COORD_ONES, v1: COORD_ONES, i0: '0, i1: '0};
			hx_q    <= '0;
			ly_q    <= '{v0: COORD_ONES, v1: COORD_ONES, i0: '0, i1: '0};
			hy_q    <= '0;
		end else if (in_fire) begin
			if (last_point) begin
				count_q <= '0;
				lx_q    <= '{v0: COORD_ONES, v1: COORD_ONES, i0: '0, i1: '0};
				hx_q    <= '0;
				ly_q    <= '{v0: COORD_ONES, v1: COORD_ONES, i0: '0, i1: '0};
				hy_q    <= '0;
			end else begin
				count_q <= count_d;
				lx_q    <= lx_d;
				hx_q    <= hx_d;
				ly_q    <= ly_d;
				hy_q    <= hy_d;
			end
		end
	end

	// Stage 1 control: a set's final extremes are held here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_ready) begin
			v_s1 <= in_fire && last_point;
		end
	end

	// Stage 1 data: snapshot of the extremes including the last point.
	always_ff @(posedge clk) begin
		if (in_fire && last_point) begin
			lx_s1    <= lx_d;
			hx_s1    <= hx_d;
			ly_s1    <= ly_d;
			hy_s1    <= hy_d;
			multi_s1 <= (count_d >= count_t'(2));
		end
	end

	// Candidate areas: the full box and the removal of each first-place point.
	always_comb begin
		drop_c[0] = '0;
		drop_c[1] = lx_s1.i0;
		drop_c[2] = hx_s1.i0;
		drop_c[3] = ly_s1.i0;
		drop_c[4] = hy_s1.i0;
		for (int k = 0; k < NUM_CAND; k++) begin
			prod_c[k] = area_t'(span(pick(hx_s1, drop_c[k], k != 0),
					pick(lx_s1, drop_c[k], k != 0)))
				* area_t'(span(pick(hy_s1, drop_c[k], k != 0),
					pick(ly_s1, drop_c[k], k != 0)));
		end
	end

	// Stage 2 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_ready) begin
			v_s2 <= v_s1;
		end
	end

	// Stage 2 data: registered products.
	always_ff @(posedge clk) begin
		if (s2_ready && v_s1) begin
			area_s2  <= prod_c;
			multi_s2 <= multi_s1;
		end
	end

	// Smallest of the candidate areas; a set of fewer than two points gives zero.
	always_comb begin
		min_c = area_s2[0];
		for (int k = 1; k < NUM_CAND; k++) begin
			if (area_s2[k] < min_c) begin
				min_c = area_s2[k];
			end
		end
		if (!multi_s2) begin
			min_c = '0;
		end
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_valid_q <= 1'b0;
		end else if (out_ready) begin
			area_valid_q <= v_s2;
		end
	end

	// Output register data.
	always_ff @(posedge clk) begin
		if (out_ready && v_s2) begin
			area_q <= OUT_BITS'(min_c);
		end
	end

	assign area_valid = area_valid_q;
	assign best_area  = area_q;

`ifndef SYNTH
	// The last point of a set always leaves an empty running state behind.
	a_set_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && last_point |=> count_q == '0)
		else $error("running count not cleared after last point");

	// The count never passes the index capacity.
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAPACITY)
		else $error("point count beyond capacity");

	// With two or more points, first place is never worse than second place.
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= count_t'(2) |-> lx_q.v0 <= lx_q.v1 && hx_q.v0 >= hx_q.v1
			&& ly_q.v0 <= ly_q.v1 && hy_q.v0 >= hy_q.v1)
		else $error("extreme pair out of order");

	// A stalled snapshot keeps its contents.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !s2_ready |=> v_s1 && $stable(lx_s1) && $stable(hx_s1)
			&& $stable(ly_s1) && $stable(hy_s1) && $stable(multi_s1))
		else $error("stage 1 lost its set under stall");
`endif

endmodule

// File: tb/sv/tb_bounding_box_drop_one_point.sv
`timescale 1ns / 100ps
// Self-checking testbench for bounding_box_drop_one_point: streams point sets over valid/ready
// and checks each best_area beat against a running top-two-extremes predictor.
// Depends on bbdop_pkg and the bounding_box_drop_one_point RTL.
module tb_bounding_box_drop_one_point;
	import bbdop_pkg::*;

	localparam int HALF_PERIOD   = 6;
	localparam int RESET_CYCLES  = 11;
	localparam int QUIET_LIMIT   = 4000;
	localparam int HOLD_CYCLES   = 250;
	localparam int RANDOM_UNTIL  = 790;
	localparam int STEADY_POINTS = 100;
	localparam int DRAIN_CYCLES  = 10;

	// Two best values on one side of one axis, with the indices of their points.
	typedef struct packed {
		coord_t lead_v;
		coord_t next_v;
		index_t lead_id;
		index_t next_id;
	} podium_t;

	logic clk;
	logic arst_n;
	logic point_valid;
	logic point_ready;
	logic [15:0] point_x;
	logic [15:0] point_y;
	logic last_point;
	logic area_valid;
	logic area_ready;
	logic [OUT_BITS-1:0] best_area;

	// Predictor state for the set in progress.
	count_t points_held;
	podium_t min_x, max_x, min_y, max_y;

	logic [OUT_BITS-1:0] pending_areas [$];
	logic [OUT_BITS-1:0] want_area;
	int fail_count = 0;
	int quiet_cycles = 0;
	int points_sent = 0;
	bit sender_gaps = 1'b0;
	bit receiver_gaps = 1'b0;
	bit hold_request = 1'b0;

	bounding_box_drop_one_point u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.point_valid (point_valid),
		.point_ready (point_ready),
		.point_x     (point_x),
		.point_y     (point_y),
		.last_point  (last_point),
		.area_valid  (area_valid),
		.area_ready  (area_ready),
		.best_area   (best_area)
	);

	// Clock generation.
	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// Insert one coordinate into a podium that keeps either the lowest or the highest pair.
	// A value equal to the leader only competes for second place.
	function automatic podium_t podium_insert(podium_t p, coord_t v, index_t id, bit keep_low,
			count_t n);
		bit beats_lead;
		bit beats_next;
		beats_lead = keep_low ? (v < p.lead_v) : (v > p.lead_v);
		beats_next = keep_low ? (v < p.next_v) : (v > p.next_v);
		if (n == 0) begin
			p.lead_v = v;
			p.lead_id = id;
		end else if (beats_lead) begin
			p.next_v = p.lead_v;
			p.next_id = p.lead_id;
			p.lead_v = v;
			p.lead_id = id;
		end else if (n == 1 || beats_next) begin
			p.next_v = v;
			p.next_id = id;
		end
		return p;
	endfunction

	// Extreme that remains when the point with index gone is taken out.
	function automatic coord_t bound_after(podium_t p, index_t gone, bit drop);
		return (drop && p.lead_id == gone) ? p.next_v : p.lead_v;
	endfunction

	// Box area of the current set, optionally without one point.
	function automatic logic [OUT_BITS-1:0] area_without(index_t gone, bit drop);
		coord_t lx, hx, ly, hy;
		logic [OUT_BITS-1:0] w, h;
		lx = bound_after(min_x, gone, drop);
		hx = bound_after(max_x, gone, drop);
		ly = bound_after(min_y, gone, drop);
		hy = bound_after(max_y, gone, drop);
		w = (hx >= lx) ? OUT_BITS'(hx) - OUT_BITS'(lx) : '0;
		h = (hy >= ly) ? OUT_BITS'(hy) - OUT_BITS'(ly) : '0;
		return w * h;
	endfunction

	// Start a fresh set in the predictor.
	task automatic clear_tracker();
		points_held = '0;
		min_x = '{lead_v: COORD_ONES, next_v: COORD_ONES, lead_id: '0, next_id: '0};
		min_y = min_x;
		max_x = '{lead_v: '0, next_v: '0, lead_id: '0, next_id: '0};
		max_y = max_x;
	endtask

	// Fold one accepted point into the predictor; on the last point queue the expected area.
	task automatic record_point(coord_t x, coord_t y, bit last);
		logic [OUT_BITS-1:0] best;
		logic [OUT_BITS-1:0] trial;
		index_t drops [4];
		if (points_held < CAPACITY) begin
			min_x = podium_insert(min_x, x, index_t'(points_held), 1'b1, points_held);
			max_x = podium_insert(max_x, x, index_t'(points_held), 1'b0, points_held);
			min_y = podium_insert(min_y, y, index_t'(points_held), 1'b1, points_held);
			max_y = podium_insert(max_y, y, index_t'(points_held), 1'b0, points_held);
			points_held++;
		end
		if (last) begin
			best = '0;
			if (points_held >= 2) begin
				best = area_without('0, 1'b0);
				drops = '{min_x.lead_id, max_x.lead_id, min_y.lead_id, max_y.lead_id};
				foreach (drops[k]) begin
					trial = area_without(drops[k], 1'b1);
					if (trial < best)
						best = trial;
				end
			end
			pending_areas.push_back(best);
			clear_tracker();
		end
	endtask

	// Offer one point beat and wait until it is taken. Valid stays high afterwards so
	// back-to-back beats follow without a gap; a gap lowers it first.
	task automatic send_point(coord_t x, coord_t y, bit last);
		if (sender_gaps && $urandom_range(0, 3) == 0) begin
			point_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		point_valid <= 1'b1;
		point_x <= x;
		point_y <= y;
		last_point <= last;
		do @(posedge clk); while (!point_ready);
		record_point(x, y, last);
		points_sent++;
	endtask

	// Coordinate drawn in one of three styles: full range, a tight cluster that makes ties,
	// or the range ends mixed with the cluster base.
	function automatic coord_t draw_coord(int style, coord_t base);
		case (style)
			0: return coord_t'($urandom);
			1: return base + coord_t'($urandom_range(0, 3));
			default: begin
				case ($urandom_range(0, 2))
					0: return '0;
					1: return COORD_ONES;
					default: return base;
				endcase
			end
		endcase
	endfunction

	// Random sets of random length ending with the last flag.
	task automatic send_random_sets(int until_count, int max_len);
		int set_len;
		int style;
		coord_t base_x, base_y;
		while (points_sent < until_count) begin
			style = $urandom_range(0, 2);
			base_x = coord_t'($urandom);
			base_y = coord_t'($urandom);
			case ($urandom_range(0, 9))
				0: set_len = 1;
				8: set_len = $urandom_range(9, max_len);
				9: set_len = $urandom_range(2, 3);
				default: set_len = $urandom_range(2, 8);
			endcase
			for (int k = 0; k < set_len; k++)
				send_point(draw_coord(style, base_x), draw_coord(style, base_y),
						k == set_len - 1);
		end
	endtask

	// Corners, a lone point, ties on the extremes and single outliers on the high side and on the low side of y.
	task automatic test_directed();
		sender_gaps = 1'b1;
		receiver_gaps = 1'b1;
		// A set of one point has no box.
		send_point(COORD_ONES, 16'd0, 1'b1);
		// Two points: dropping either leaves a degenerate box.
		send_point(16'd0, COORD_ONES, 1'b0);
		send_point(COORD_ONES, 16'd0, 1'b1);
		// Four corners: every extreme is shared, so the full box is the answer.
		send_point(16'd0, 16'd0, 1'b0);
		send_point(COORD_ONES, 16'd0, 1'b0);
		send_point(16'd0, COORD_ONES, 1'b0);
		send_point(COORD_ONES, COORD_ONES, 1'b1);
		// Duplicated points on both extremes.
		send_point(16'd10, 16'd10, 1'b0);
		send_point(16'd10, 16'd10, 1'b0);
		send_point(16'd20, 16'd20, 1'b0);
		send_point(16'd20, 16'd20, 1'b1);
		// Outlier on the high side of both axes.
		send_point(16'd100, 16'd100, 1'b0);
		send_point(16'd101, 16'd102, 1'b0);
		send_point(16'd103, 16'd101, 1'b0);
		send_point(16'd60000, 16'd50000, 1'b1);
		// Outlier on the low side of y only.
		send_point(16'd30000, 16'd0, 1'b0);
		send_point(16'd30001, 16'd30003, 1'b0);
		send_point(16'd30004, 16'd30001, 1'b0);
		send_point(16'd30002, 16'd30002, 1'b1);
	endtask

	// The bulk of the random sets with idling switched per set.
	task automatic test_random_sets();
		while (points_sent < RANDOM_UNTIL) begin
			sender_gaps = ($urandom_range(0, 4) != 0);
			receiver_gaps = ($urandom_range(0, 4) != 0);
			send_random_sets(points_sent + 1, 40);
		end
	endtask

	// The receiver holds off for a long stretch while short sets keep coming, so the result
	// stages fill and the point input stalls.
	task automatic test_backpressure();
		sender_gaps = 1'b0;
		receiver_gaps = 1'b0;
		hold_request = 1'b1;
		for (int s = 0; s < 30; s++) begin
			send_point(coord_t'($urandom), coord_t'($urandom), 1'b0);
			send_point(coord_t'($urandom), coord_t'($urandom), 1'b1);
		end
	endtask

	// Closing stretch at full rate on both sides.
	task automatic test_steady_stream();
		sender_gaps = 1'b0;
		receiver_gaps = 1'b0;
		send_random_sets(points_sent + STEADY_POINTS, 12);
	endtask

	// Result receiver: random stall bursts, or one long hold when asked.
	initial begin
		area_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				area_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else if (receiver_gaps && $urandom_range(0, 7) == 0) begin
				area_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			area_ready <= 1'b1;
		end
	end

	// Compare each area beat with the oldest expected area.
	always @(posedge clk) begin
		if (arst_n && area_valid && area_ready) begin
			if (pending_areas.size() == 0) begin
				$error("best_area: beat with value %0d while no set is outstanding", best_area);
				fail_count++;
			end else begin
				want_area = pending_areas.pop_front();
				if (best_area !== want_area) begin
					$error("best_area: expected %0d, got %0d", want_area, best_area);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on cycles with no beat on either channel.
	always @(posedge clk) begin
		if (!arst_n || (point_valid && point_ready) || (area_valid && area_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Reset, run the tests in turn, drain and report.
	initial begin
		arst_n = 1'b0;
		point_valid = 1'b0;
		point_x = '0;
		point_y = '0;
		last_point = 1'b0;
		clear_tracker();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_sets();
		test_backpressure();
		test_steady_stream();
		point_valid <= 1'b0;
		while (pending_areas.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: files.f
rtl/bbdop_pkg.sv
rtl/bounding_box_drop_one_point.sv
tb/sv/tb_bounding_box_drop_one_point.sv
